/* rtl/dws_pkg.sv */
// Shared types and constants for the DDS waveform sample generator.
// Holds the sine table, the waveform codes, the register indexes and the stage control struct.
// No dependencies.
`timescale 1ns / 1ps

package dws_pkg;

   // waveform selector codes; any other code gives sine
   localparam logic [1:0] WAVE_SINE     = 2'd0;
   localparam logic [1:0] WAVE_TRIANGLE = 2'd1;
   localparam logic [1:0] WAVE_SQUARE   = 2'd2;

   // configuration register indexes
   localparam logic [1:0] REG_WAVE_SELECT = 2'd0;
   localparam logic [1:0] REG_PHASE_STEP  = 2'd1;
   localparam logic [1:0] REG_GAIN        = 2'd2;
   localparam logic [1:0] REG_START_PHASE = 2'd3;

   // register reset values
   localparam logic [1:0]  WAVE_SELECT_RST = WAVE_SINE;
   localparam logic [31:0] PHASE_STEP_RST  = 32'd8388608;
   localparam logic [16:0] GAIN_RST        = 17'd39718;
   localparam logic [31:0] START_PHASE_RST = 32'd0;

   // fixed codes
   localparam logic [16:0] FULL_GAIN = 17'd65536;
   localparam logic [11:0] MAX_CODE  = 12'd4095;
   localparam logic [11:0] MID_CODE  = 12'd2048;

   // stage enables handed from the sequencer to the waveform unit
   typedef struct packed {
      logic rom_en;   // latch the two table entries and the fraction
      logic mul_en;   // latch the interpolation product
      logic raw_en;   // latch the raw waveform value
   } dws_stage_ctl_type;

   // one period of sine, centered at mid code
   localparam logic [11:0] SINE_ROM [256] = '{
      12'd2048, 12'd2098, 12'd2148, 12'd2199, 12'd2249, 12'd2299, 12'd2348, 12'd2398,
      12'd2447, 12'd2497, 12'd2545, 12'd2594, 12'd2642, 12'd2690, 12'd2738, 12'd2785,
      12'd2831, 12'd2878, 12'd2923, 12'd2968, 12'd3013, 12'd3057, 12'd3100, 12'd3143,
      12'd3185, 12'd3227, 12'd3267, 12'd3307, 12'd3347, 12'd3385, 12'd3423, 12'd3459,
      12'd3495, 12'd3531, 12'd3565, 12'd3598, 12'd3630, 12'd3662, 12'd3692, 12'd3722,
      12'd3750, 12'd3777, 12'd3804, 12'd3829, 12'd3853, 12'd3876, 12'd3898, 12'd3919,
      12'd3939, 12'd3958, 12'd3975, 12'd3992, 12'd4007, 12'd4021, 12'd4034, 12'd4045,
      12'd4056, 12'd4065, 12'd4073, 12'd4080, 12'd4085, 12'd4089, 12'd4093, 12'd4094,
      12'd4095, 12'd4094, 12'd4093, 12'd4089, 12'd4085, 12'd4080, 12'd4073, 12'd4065,
      12'd4056, 12'd4045, 12'd4034, 12'd4021, 12'd4007, 12'd3992, 12'd3975, 12'd3958,
      12'd3939, 12'd3919, 12'd3898, 12'd3876, 12'd3853, 12'd3829, 12'd3804, 12'd3777,
      12'd3750, 12'd3722, 12'd3692, 12'd3662, 12'd3630, 12'd3598, 12'd3565, 12'd3531,
      12'd3495, 12'd3459, 12'd3423, 12'd3385, 12'd3347, 12'd3307, 12'd3267, 12'd3227,
      12'd3185, 12'd3143, 12'd3100, 12'd3057, 12'd3013, 12'd2968, 12'd2923, 12'd2878,
      12'd2831, 12'd2785, 12'd2738, 12'd2690, 12'd2642, 12'd2594, 12'd2545, 12'd2497,
      12'd2447, 12'd2398, 12'd2348, 12'd2299, 12'd2249, 12'd2199, 12'd2148, 12'd2098,
      12'd2048, 12'd1998, 12'd1948, 12'd1897, 12'd1847, 12'd1797, 12'd1748, 12'd1698,
      12'd1649, 12'd1599, 12'd1551, 12'd1502, 12'd1454, 12'd1406, 12'd1358, 12'd1311,
      12'd1265, 12'd1218, 12'd1173, 12'd1128, 12'd1083, 12'd1039, 12'd996,  12'd953,
      12'd911,  12'd869,  12'd829,  12'd789,  12'd749,  12'd711,  12'd673,  12'd637,
      12'd601,  12'd565,  12'd531,  12'd498,  12'd466,  12'd434,  12'd404,  12'd374,
      12'd346,  12'd319,  12'd292,  12'd267,  12'd243,  12'd220,  12'd198,  12'd177,
      12'd157,  12'd138,  12'd121,  12'd104,  12'd89,   12'd75,   12'd62,   12'd51,
      12'd40,   12'd31,   12'd23,   12'd16,   12'd11,   12'd7,    12'd3,    12'd2,
      12'd1,    12'd2,    12'd3,    12'd7,    12'd11,   12'd16,   12'd23,   12'd31,
      12'd40,   12'd51,   12'd62,   12'd75,   12'd89,   12'd104,  12'd121,  12'd138,
      12'd157,  12'd177,  12'd198,  12'd220,  12'd243,  12'd267,  12'd292,  12'd319,
      12'd346,  12'd374,  12'd404,  12'd434,  12'd466,  12'd498,  12'd531,  12'd565,
      12'd601,  12'd637,  12'd673,  12'd711,  12'd749,  12'd789,  12'd829,  12'd869,
      12'd911,  12'd953,  12'd996,  12'd1039, 12'd1083, 12'd1128, 12'd1173, 12'd1218,
      12'd1265, 12'd1311, 12'd1358, 12'd1406, 12'd1454, 12'd1502, 12'd1551, 12'd1599,
      12'd1649, 12'd1698, 12'd1748, 12'd1797, 12'd1847, 12'd1897, 12'd1948, 12'd1998
   };

endpackage

/* rtl/dws_phase_mem.sv */
// Phase accumulator store: one-word synchronous memory with registered read.
// A valid bit makes the word read as zero until the first write after reset.
// No package dependencies.
`timescale 1ns / 1ps

module dws_phase_mem (
   input  logic        clock,
   input  logic        reset,
   input  logic        rd_en,
   input  logic        wr_en,
   input  logic [31:0] wr_data,
   output logic [31:0] rd_data
);

   logic [31:0] mem_ff;
   logic        written_ff;
   logic [31:0] rd_data_ff;

   // write the stored word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff <= wr_data;
      end
   end

   // track whether the word holds a real value
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= 1'b0;
      end else if (wr_en) begin
         written_ff <= 1'b1;
      end
   end

   // registered read, forwarding a write in the same cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en) begin
            rd_data_ff <= wr_data;
         end else if (written_ff) begin
            rd_data_ff <= mem_ff;
         end else begin
            rd_data_ff <= 32'd0;
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/dws_wave_unit.sv */
// Waveform unit: sine table lookup with linear interpolation, triangle and square.
// Three registered steps driven by the sequencer's stage enables.
// Depends on dws_pkg.
`timescale 1ns / 1ps

module dws_wave_unit (
   input  logic                       clock,
   input  dws_pkg::dws_stage_ctl_type ctl,
   input  logic [1:0]                 wave_select,
   input  logic [31:0]                phase,
   output logic [11:0]                raw
);

   import dws_pkg::*;

   logic [7:0]         idx0;
   logic [7:0]         idx1;
   logic [11:0]        v0_ff;
   logic [11:0]        v1_ff;
   logic [15:0]        frac_ff;
   logic signed [12:0] diff;
   logic signed [16:0] frac_s;
   logic signed [29:0] prod_in;
   logic signed [29:0] prod_ff;
   logic signed [29:0] prod_bias;
   logic signed [13:0] interp;
   logic signed [12:0] sine_sum;
   logic [9:0]         tri_pos;
   logic [11:0]        raw_in;
   logic [11:0]        raw_ff;

   assign idx0 = phase[31:24];
   assign idx1 = idx0 + 8'd1;

   // latch the neighboring table entries and the fraction
   always_ff @(posedge clock) begin
      if (ctl.rom_en) begin
         v0_ff   <= SINE_ROM[idx0];
         v1_ff   <= SINE_ROM[idx1];
         frac_ff <= phase[23:8];
      end
   end

   // multiply the slope by the fraction
   assign diff    = $signed({1'b0, v1_ff}) - $signed({1'b0, v0_ff});
   assign frac_s  = $signed({1'b0, frac_ff});
   assign prod_in = 30'(diff) * 30'(frac_s);

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
      end
   end

   // divide by 65536 truncating toward zero: bias negative products first
   assign prod_bias = prod_ff + (prod_ff[29] ? 30'sh0000FFFF : 30'sh00000000);
   assign interp    = prod_bias[29:16];
   assign sine_sum  = $signed({1'b0, v0_ff}) + interp[12:0];

   assign tri_pos = phase[31:22];

   // pick the raw value for the selected waveform
   always_comb begin
      unique case (wave_select)
         WAVE_TRIANGLE: begin
            if (!tri_pos[9]) begin
               raw_in = {tri_pos[8:0], 3'b000};
            end else begin
               raw_in = {~tri_pos[8:0], 3'b000};
            end
         end
         WAVE_SQUARE: begin
            raw_in = phase[31] ? 12'd0 : MAX_CODE;
         end
         default: begin
            raw_in = sine_sum[11:0];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.raw_en) begin
         raw_ff <= raw_in;
      end
   end

   assign raw = raw_ff;

endmodule

/* rtl/dds_waveform_sample_generator.sv */
// DDS waveform sample generator: 32-bit phase accumulator, sine/triangle/square, gain.
// One item in flight at a time: a new item is accepted only when the sequencer is idle and
// no result is pending. The sequencer walks each item through phase read, table read,
// interpolation multiply, raw waveform select, gain multiply and output.
// Reset (synchronous, active high): registers take their reset values, accumulator reads 0.
// Depends on dws_pkg, dws_phase_mem, dws_wave_unit.
`timescale 1ns / 1ps

module dds_waveform_sample_generator (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_restart,
   // result items
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_sample,
   output logic [31:0] rsp_phase_used,
   // configuration writes
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   import dws_pkg::*;

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PHASE = 3'd1;
   localparam logic [2:0] ST_ROM   = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_RAW   = 3'd4;
   localparam logic [2:0] ST_SCALE = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   logic [2:0]         state_ff;
   logic [2:0]         state_in;
   logic [1:0]         wave_select_ff;
   logic [31:0]        phase_step_ff;
   logic [16:0]        gain_ff;
   logic [31:0]        start_phase_ff;
   logic               restart_ff;
   logic [31:0]        phase_ff;
   logic [31:0]        phase_in;
   logic [31:0]        mem_rd_data;
   logic               req_accept;
   logic               rsp_valid_ff;
   logic [11:0]        rsp_sample_ff;
   logic [31:0]        rsp_phase_ff;
   dws_stage_ctl_type  stage_ctl;
   logic [11:0]        raw;
   logic [16:0]        gain_sat;
   logic signed [12:0] centered;
   logic signed [17:0] gain_s;
   logic signed [30:0] scale_in;
   logic signed [30:0] scale_ff;
   logic signed [30:0] scale_bias;
   logic signed [15:0] scaled;
   logic [11:0]        sample_in;

   // hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wave_select_ff <= WAVE_SELECT_RST;
         phase_step_ff  <= PHASE_STEP_RST;
         gain_ff        <= GAIN_RST;
         start_phase_ff <= START_PHASE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_WAVE_SELECT: wave_select_ff <= csr_wdata[1:0];
            REG_PHASE_STEP:  phase_step_ff  <= csr_wdata;
            REG_GAIN:        gain_ff        <= csr_wdata[16:0];
            REG_START_PHASE: start_phase_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign req_ready  = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_accept = req_valid && req_ready;

   // advance the sequencer one step per cycle once an item is in
   always_comb begin
      unique case (state_ff)
         ST_IDLE:  state_in = req_accept ? ST_PHASE : ST_IDLE;
         ST_PHASE: state_in = ST_ROM;
         ST_ROM:   state_in = ST_MUL;
         ST_MUL:   state_in = ST_RAW;
         ST_RAW:   state_in = ST_SCALE;
         ST_SCALE: state_in = ST_OUT;
         ST_OUT:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // capture the restart flag with the item
   always_ff @(posedge clock) begin
      if (req_accept) begin
         restart_ff <= req_restart;
      end
   end

   // phase store: read on accept, write back the advanced phase in the following cycle
   assign phase_in = restart_ff ? start_phase_ff : mem_rd_data;

   dws_phase_mem u_phase_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .wr_en   (state_ff == ST_PHASE),
      .wr_data (phase_in + phase_step_ff),
      .rd_data (mem_rd_data)
   );

   always_ff @(posedge clock) begin
      if (state_ff == ST_PHASE) begin
         phase_ff <= phase_in;
      end
   end

   // waveform generation
   assign stage_ctl.rom_en = (state_ff == ST_ROM);
   assign stage_ctl.mul_en = (state_ff == ST_MUL);
   assign stage_ctl.raw_en = (state_ff == ST_RAW);

   dws_wave_unit u_wave_unit (
      .clock       (clock),
      .ctl         (stage_ctl),
      .wave_select (wave_select_ff),
      .phase       (phase_ff),
      .raw         (raw)
   );

   // scale around mid code by the saturated gain
   assign gain_sat = (gain_ff > FULL_GAIN) ? FULL_GAIN : gain_ff;
   assign centered = $signed({1'b0, raw}) - $signed({1'b0, MID_CODE});
   assign gain_s   = $signed({1'b0, gain_sat});
   assign scale_in = 31'(centered) * 31'(gain_s);

   always_ff @(posedge clock) begin
      if (state_ff == ST_SCALE) begin
         scale_ff <= scale_in;
      end
   end

   // divide by 65536 toward zero, offset back and clamp
   assign scale_bias = scale_ff + (scale_ff[30] ? 31'sh0000FFFF : 31'sh00000000);
   assign scaled     = $signed({scale_bias[30], scale_bias[30:16]})
                       + $signed({4'b0000, MID_CODE});

   always_comb begin
      priority if (scaled < 16'sd0) begin
         sample_in = 12'd0;
      end else if (scaled > $signed({4'b0000, MAX_CODE})) begin
         sample_in = MAX_CODE;
      end else begin
         sample_in = scaled[11:0];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT) begin
         rsp_sample_ff <= sample_in;
         rsp_phase_ff  <= phase_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample     = rsp_sample_ff;
   assign rsp_phase_used = rsp_phase_ff;

   // a result appears only out of the output step
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("result raised outside output step");

   // no item is in flight while a result is pending
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !rsp_valid_ff)
      else $error("item in flight while result pending");

   // an accepted item always goes to the phase step next
   a_accept_to_phase: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_PHASE)
      else $error("accepted item did not start phase step");

   // a taken result leaves the output empty
   a_rsp_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> !rsp_valid_ff)
      else $error("result repeated after being taken");

endmodule

/* sim/tb.sv */
// Testbench for dds_waveform_sample_generator: predicts every sample and phase it produces.
// Runs directed corner items, then randomized register settings with idling and stalls.
// Depends on dws_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module tb;
   import dws_pkg::*;

   localparam int LONG_HOLD    = 200;
   localparam int DRAIN_CYCLES = 10;
   localparam int RANDOM_ITEMS = 1500;
   localparam int CALM_AFTER   = 1250;

   typedef struct {
      logic [11:0] sample;
      logic [31:0] phase;
   } dds_sample_type;

   // register shadow, phase accumulator and queue of predicted samples
   class dds_sample_board_type;
      logic [1:0]     wave_sel;
      logic [31:0]    step;
      logic [16:0]    gain;
      logic [31:0]    start;
      logic [31:0]    accum;
      dds_sample_type pending_samples[$];
      int             errors;
      int             checked;
      int             noted;
      int             restarts;
      int             writes;
      int             wave_hits[4];

      function void reset_state();
         wave_sel = WAVE_SELECT_RST;
         step     = PHASE_STEP_RST;
         gain     = GAIN_RST;
         start    = START_PHASE_RST;
         accum    = '0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] data);
         writes++;
         case (idx)
            REG_WAVE_SELECT: wave_sel = data[1:0];
            REG_PHASE_STEP:  step     = data;
            REG_GAIN:        gain     = data[16:0];
            REG_START_PHASE: start    = data;
            default: ;
         endcase
      endfunction

      // raw 12-bit waveform level at a given phase
      function longint raw_level(logic [31:0] ph);
         longint     tri_pos;
         longint     v0;
         longint     v1;
         longint     frac;
         logic [7:0] idx0;
         logic [7:0] idx1;
         case (wave_sel)
            WAVE_TRIANGLE: begin
               tri_pos = longint'(ph[31:22]);
               return (tri_pos < 512) ? tri_pos * 8 : (1023 - tri_pos) * 8;
            end
            WAVE_SQUARE: return ph[31] ? 64'sd0 : 64'sd4095;
            default: begin
               // interpolate between neighboring table entries, wrapping at the end
               idx0 = ph[31:24];
               idx1 = idx0 + 8'd1;
               frac = longint'(ph[23:8]);
               v0   = longint'(SINE_ROM[idx0]);
               v1   = longint'(SINE_ROM[idx1]);
               return v0 + ((v1 - v0) * frac) / 65536;
            end
         endcase
      endfunction

      // center, scale by the saturated gain, recenter and clamp
      function logic [11:0] predict_sample(logic [31:0] ph);
         longint mid;
         longint top;
         longint full;
         longint g;
         longint scaled;
         mid    = longint'(MID_CODE);
         top    = longint'(MAX_CODE);
         full   = longint'(FULL_GAIN);
         g      = (gain > FULL_GAIN) ? full : longint'(gain);
         scaled = ((raw_level(ph) - mid) * g) / 65536 + mid;
         if (scaled > top) scaled = top;
         if (scaled < 0) scaled = 0;
         return 12'(scaled);
      endfunction

      function void note_item(logic restart);
         dds_sample_type s;
         if (restart) begin
            accum = start;
            restarts++;
         end
         s.phase  = accum;
         s.sample = predict_sample(accum);
         pending_samples.push_back(s);
         wave_hits[wave_sel]++;
         accum = accum + step;
         noted++;
      endfunction

      task report_mismatch(string msg);
         $display("ERROR @%0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_result(logic [11:0] got_sample, logic [31:0] got_phase);
         dds_sample_type s;
         if (pending_samples.size() == 0) begin
            report_mismatch($sformatf("unexpected item: sample %0d phase %h",
                                      got_sample, got_phase));
            return;
         end
         s = pending_samples.pop_front();
         checked++;
         if (got_sample !== s.sample)
            report_mismatch($sformatf("sample %0d, expected %0d (phase %h)",
                                      got_sample, s.sample, s.phase));
         if (got_phase !== s.phase)
            report_mismatch($sformatf("phase_used %h, expected %h", got_phase, s.phase));
      endtask
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   logic        req_restart = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   logic [11:0] rsp_sample;
   logic [31:0] rsp_phase_used;
   logic        csr_we      = 1'b0;
   logic [1:0]  csr_index   = REG_WAVE_SELECT;
   logic [31:0] csr_wdata   = '0;

   bit hold_request = 1'b0;
   bit calm         = 1'b0;
   int long_holds   = 0;

   dds_sample_board_type board = new();

   dds_waveform_sample_generator uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_restart    (req_restart),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample     (rsp_sample),
      .rsp_phase_used (rsp_phase_used),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // track writes, accepted items and returned items at each rising edge
   always @(posedge clock) begin
      if (reset) begin
         board.reset_state();
      end else begin
         if (csr_we) board.write_reg(csr_index, csr_wdata);
         if (req_valid && req_ready) board.note_item(req_restart);
         if (rsp_valid && rsp_ready) board.check_result(rsp_sample, rsp_phase_used);
      end
   end

   // receiver: random stall bursts, quiet stretches, one long hold-off on request
   initial begin : receiver
      bit quiet;
      quiet = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            long_holds++;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
         end else if (!calm && !quiet && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 8)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
         if ($urandom_range(0, 39) == 0) quiet = !quiet;
      end
   end

   // offer one item and hold it until accepted; returns at a falling edge
   task automatic send_item(input logic restart);
      req_valid   <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic pause_sender(input int cycles);
      req_valid   <= 1'b0;
      req_restart <= 1'($urandom_range(0, 1));
      repeat (cycles) @(negedge clock);
   endtask

   // drop valid and wait until every predicted sample has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.pending_samples.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_one(input logic [1:0] idx, input logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   // write the selected registers while the block is idle
   task automatic apply_settings(input logic [3:0] which, input logic [31:0] wave,
                                 input logic [31:0] step, input logic [31:0] g,
                                 input logic [31:0] st);
      wait_drained();
      if (which[REG_WAVE_SELECT]) write_one(REG_WAVE_SELECT, wave);
      if (which[REG_PHASE_STEP])  write_one(REG_PHASE_STEP, step);
      if (which[REG_GAIN])        write_one(REG_GAIN, g);
      if (which[REG_START_PHASE]) write_one(REG_START_PHASE, st);
      csr_we <= 1'b0;
   endtask

   // one randomized setting followed by a burst of items
   task automatic random_phase(input int n_items, input bit long_hold);
      logic [31:0] wave;
      logic [31:0] step;
      logic [31:0] g;
      logic [31:0] st;
      bit          gaps_on;
      wave = $urandom;
      case ($urandom_range(0, 5))
         0:       step = '0;
         1:       step = 32'd1;
         2:       step = 32'hFFFF_FFFF;
         3:       step = 32'd1 << $urandom_range(0, 31);
         4:       step = $urandom_range(1, 32'h0100_0000);
         default: step = $urandom;
      endcase
      case ($urandom_range(0, 5))
         0:       g = '0;
         1:       g = 32'd65535;
         2:       g = 32'(FULL_GAIN);
         3:       g = $urandom_range(65537, 131071);
         4:       g = $urandom;
         default: g = $urandom_range(0, 65536);
      endcase
      case ($urandom_range(0, 3))
         0:       st = '0;
         1:       st = 32'hFFFF_FFFF;
         2:       st = {8'($urandom_range(0, 255)), 24'h0};
         default: st = $urandom;
      endcase
      apply_settings(($urandom_range(0, 2) == 0) ? 4'hF : 4'($urandom_range(1, 15)),
                     wave, step, g, st);
      gaps_on      = !calm && ($urandom_range(0, 3) != 0);
      hold_request = long_hold;
      for (int i = 0; i < n_items; i++) begin
         send_item($urandom_range(0, 19) == 0);
         if (gaps_on && $urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 9));
      end
   endtask

   initial begin : stimulus
      int phases;
      phases = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: sine at the default step, then a restart back to zero
      send_item(1'b0);
      send_item(1'b0);
      send_item(1'b1);

      // sine at the last table entry, wrapping step, gain above full scale
      apply_settings(4'hF, 32'(WAVE_SINE), 32'hFFFF_FFFF, 32'h0001_FFFF, 32'hFFFF_FFFF);
      send_item(1'b1);
      send_item(1'b0);
      send_item(1'b0);

      // unused selector code behaves as sine
      apply_settings(4'hF, 32'd3, 32'h0080_0000, 32'd65535, 32'h00FF_FF00);
      send_item(1'b1);
      send_item(1'b0);

      // triangle around its peak, then the top of the range wrapping to zero
      apply_settings(4'hF, 32'(WAVE_TRIANGLE), 32'h0040_0000, 32'(FULL_GAIN),
                     32'h7FC0_0000);
      send_item(1'b1);
      send_item(1'b0);
      send_item(1'b0);
      apply_settings(4'b1000, '0, '0, '0, 32'hFFC0_0000);
      send_item(1'b1);
      send_item(1'b0);

      // square at zero gain, then at full scale across the half-period edge
      apply_settings(4'hF, 32'(WAVE_SQUARE), 32'h8000_0000, '0, 32'h7FFF_FFFF);
      send_item(1'b1);
      send_item(1'b0);
      apply_settings(4'b0100, '0, '0, 32'(FULL_GAIN), '0);
      send_item(1'b1);
      send_item(1'b0);
      send_item(1'b0);

      // randomized phases; the last stretch runs without idling
      while (board.noted < RANDOM_ITEMS) begin
         calm = (board.noted >= CALM_AFTER);
         random_phase($urandom_range(20, 120), phases == 3);
         phases++;
      end

      wait_drained();
      $display("checked %0d samples over %0d settings, %0d restarts, %0d register writes",
               board.checked, phases, board.restarts, board.writes);
      $display("waveform items sine/triangle/square/alt-sine %0d/%0d/%0d/%0d, long holds %0d",
               board.wave_hits[0], board.wave_hits[1], board.wave_hits[2],
               board.wave_hits[3], long_holds);
      if (board.errors == 0 && board.pending_samples.size() == 0) begin
         $display("dds_waveform_sample_generator: match");
      end else begin
         $display("dds_waveform_sample_generator: mismatch");
      end
      $finish;
   end

   // stop a hung run
   initial begin : watchdog
      #5_000_000;
      $display("dds_waveform_sample_generator: mismatch");
      $finish;
   end

endmodule
